FILE: sv/swq_pkg.sv
// ----------------------------------------------------------------------------
// swq_pkg
// Shared types and constants of the sliding window quantile filter.
// ----------------------------------------------------------------------------
package swq_pkg;

    localparam int WinDepth = 64;
    localparam int IdxW     = $clog2(WinDepth);
    localparam int CntW     = $clog2(WinDepth + 1);
    localparam int SmpW     = 16;
    localparam int ProbW    = 16;

    localparam logic [ProbW-1:0] ProbReset = ProbW'(32768);

    typedef logic signed [SmpW-1:0] t_sample;
    typedef logic [IdxW-1:0]        t_idx;
    typedef logic [CntW-1:0]        t_cnt;

    // Item kinds
    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REMOVE = 2'd1,
        K_CLEAR  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    // Operation broadcast to every sorted cell
    typedef enum logic [1:0] {
        C_HOLD,
        C_INSERT,
        C_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_sample  key;
    } t_chain_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_REPORT
    } t_state;

endpackage

FILE: sv/swq_cell.sv
// ----------------------------------------------------------------------------
// swq_cell
// One slot of the sorted row. Keeps its value on hold, shifts right on insert
// above the key, shifts left on delete at or above the key.
// ----------------------------------------------------------------------------
module swq_cell
    import swq_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_in_use,
    input  t_sample     i_left_value,
    input  logic        i_left_gt,
    input  t_sample     i_right_value,
    output t_sample     o_value,
    output logic        o_gt
);

    t_sample r_value;
    t_sample n_value;
    logic    w_ge;

    // unused slots count as above any key so the insert point is found
    assign o_gt = !i_in_use || (r_value > i_ctrl.key);
    assign w_ge = i_in_use && (r_value >= i_ctrl.key);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            C_INSERT: begin
                if (o_gt) begin
                    n_value = i_left_gt ? i_left_value : i_ctrl.key;
                end
            end
            C_DELETE: begin
                // first slot at or above the key holds the removed value
                if (w_ge) begin
                    n_value = i_right_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: sv/swq_sorted_chain.sv
// ----------------------------------------------------------------------------
// swq_sorted_chain
// Row of sorted cells in ascending order, with the min, max and rank taps.
// ----------------------------------------------------------------------------
module swq_sorted_chain
    import swq_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  t_cnt        i_count,
    input  t_idx        i_rank,
    output t_sample     o_min,
    output t_sample     o_max,
    output t_sample     o_quant
);

    t_sample w_value [WinDepth];
    logic    w_gt    [WinDepth];
    t_cnt    w_last;

    for (genvar g = 0; g < WinDepth; g++) begin : g_cell
        t_sample w_left;
        logic    w_left_gt;
        t_sample w_right;

        if (g == 0) begin : g_first
            assign w_left    = i_ctrl.key;
            assign w_left_gt = 1'b0;
        end else begin : g_mid
            assign w_left    = w_value[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == WinDepth - 1) begin : g_end
            assign w_right = w_value[g];
        end else begin : g_inner
            assign w_right = w_value[g+1];
        end

        swq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_in_use     (CntW'(g) < i_count),
            .i_left_value (w_left),
            .i_left_gt    (w_left_gt),
            .i_right_value(w_right),
            .o_value      (w_value[g]),
            .o_gt         (w_gt[g])
        );
    end

    assign w_last  = i_count - CntW'(1);
    assign o_min   = w_value[0];
    assign o_max   = w_value[w_last[IdxW-1:0]];
    assign o_quant = w_value[i_rank];

endmodule

FILE: sv/sliding_window_quantile_core.sv
// ----------------------------------------------------------------------------
// sliding_window_quantile_core
// Rank-order filter over a window of up to 64 signed 16-bit samples. An item
// adds a sample, drops the oldest one or clears the window, and yields one
// result with min, max, count and the sample at rank floor(prob*count/65536).
// Each item passes through the accept, update and report states. In the update
// state the sorted row shifts, keyed by the oldest sample that the arrival-order
// memory has already read out, and the rank product is registered beside it.
// In the report state the row is tapped into the output register, and that
// state repeats while the previous result has not been taken. The input is
// taken again while a previous result still waits at the output register.
// ----------------------------------------------------------------------------
module sliding_window_quantile_core
    import swq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_kind,
    input  logic signed [15:0]     i_sample,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [15:0]     o_min_value,
    output logic signed [15:0]     o_max_value,
    output logic signed [15:0]     o_quantile_value,
    output logic [6:0]             o_sample_count,
    output logic                   o_is_empty,
    output logic                   o_overflow
);

    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_kind;
    t_sample            r_sample;
    t_cnt               r_count;
    t_cnt               n_count;
    t_idx               r_oldest;
    t_idx               n_oldest;
    logic [ProbW-1:0]   r_prob;
    t_idx               r_rank;
    logic               r_drop;
    t_sample            r_rd_data;
    t_sample            r_mem [WinDepth];

    logic               w_accept;
    logic               w_apply;
    logic               w_report;
    logic               w_out_free;
    logic               w_full;
    logic               w_do_add;
    logic               w_do_remove;
    logic [CntW:0]      w_tail_sum;
    t_idx               w_tail;
    logic [ProbW+CntW-1:0] w_prod;
    t_chain_ctrl        w_ctrl;
    t_sample            w_min;
    t_sample            w_max;
    t_sample            w_quant;

    assign o_cfg_ready = i_rst_n;
    assign w_out_free  = !o_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_APPLY;
            S_APPLY:  n_state = S_REPORT;
            S_REPORT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_apply    = 1'b0;
        w_report   = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = i_rst_n;
            S_APPLY:  w_apply    = 1'b1;
            S_REPORT: w_report   = w_out_free;
            default:  o_in_ready = 1'b0;
        endcase
    end

    assign w_full      = (r_count >= CntW'(WinDepth));
    assign w_do_add    = (r_kind == K_ADD) && !w_full;
    assign w_do_remove = (r_kind == K_REMOVE) && (r_count != '0);

    assign w_tail_sum = {1'b0, r_count} + (CntW+1)'(r_oldest);
    assign w_tail     = (w_tail_sum >= (CntW+1)'(WinDepth))
                      ? IdxW'(w_tail_sum - (CntW+1)'(WinDepth))
                      : IdxW'(w_tail_sum);

    always_comb begin
        n_count  = r_count;
        n_oldest = r_oldest;
        if (w_do_add) begin
            n_count = r_count + CntW'(1);
        end else if (w_do_remove) begin
            n_count  = r_count - CntW'(1);
            n_oldest = (r_oldest == IdxW'(WinDepth - 1)) ? '0 : r_oldest + IdxW'(1);
        end else if (r_kind == K_CLEAR) begin
            n_count  = '0;
            n_oldest = '0;
        end
    end

    assign w_prod = {{CntW{1'b0}}, r_prob} * {{ProbW{1'b0}}, n_count};

    always_comb begin
        w_ctrl.key = w_do_remove ? r_rd_data : r_sample;
        w_ctrl.op  = C_HOLD;
        if (w_apply && w_do_add) begin
            w_ctrl.op = C_INSERT;
        end else if (w_apply && w_do_remove) begin
            w_ctrl.op = C_DELETE;
        end
    end

    swq_sorted_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_count(r_count),
        .i_rank (r_rank),
        .o_min  (w_min),
        .o_max  (w_max),
        .o_quant(w_quant)
    );

    // arrival-order store; read the oldest sample every cycle
    always_ff @(posedge i_clk) begin
        if (w_apply && w_do_add) begin
            r_mem[w_tail] <= r_sample;
        end
        r_rd_data <= r_mem[r_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_prob      <= ProbReset;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_prob <= i_cfg_data;
            end
            if (w_apply) begin
                r_count  <= n_count;
                r_oldest <= n_oldest;
            end
            if (w_report) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_kind;
            r_sample <= i_sample;
        end
        if (w_apply) begin
            r_rank <= IdxW'(w_prod >> ProbW);
            r_drop <= (r_kind == K_ADD) && w_full;
        end
        if (w_report) begin
            o_is_empty       <= (r_count == '0);
            o_overflow       <= r_drop;
            o_sample_count   <= 7'(r_count);
            o_min_value      <= (r_count == '0) ? '0 : w_min;
            o_max_value      <= (r_count == '0) ? '0 : w_max;
            o_quantile_value <= (r_count == '0) ? '0 : w_quant;
        end
    end

endmodule

FILE: sv/swq_checker.sv
// ----------------------------------------------------------------------------
// swq_checker
// Port-level checks of the quantile filter, bound to the top level.
// ----------------------------------------------------------------------------
module swq_checker
    import swq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] o_min_value,
    input  logic signed [15:0] o_max_value,
    input  logic signed [15:0] o_quantile_value,
    input  logic [6:0]         o_sample_count,
    input  logic               o_is_empty,
    input  logic               o_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped before it was taken");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a transaction is in progress");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_sample_count == 7'd0 && o_min_value == 16'sd0
            && o_max_value == 16'sd0 && o_quantile_value == 16'sd0)
        else $error("empty window reports nonzero fields");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_empty |-> o_min_value <= o_quantile_value
            && o_quantile_value <= o_max_value)
        else $error("quantile outside min and max");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_sample_count == 7'(WinDepth) && !o_is_empty)
        else $error("overflow flagged on a window that is not full");

endmodule

bind sliding_window_quantile_core swq_checker u_swq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_min_value     (o_min_value),
    .o_max_value     (o_max_value),
    .o_quantile_value(o_quantile_value),
    .o_sample_count  (o_sample_count),
    .o_is_empty      (o_is_empty),
    .o_overflow      (o_overflow)
);
